// File: rtl/sss_pkg.sv
// Package of the stepper step sequencer: codes, widths, control structs and
// coil tables. Used by every other file of the block but sss_out_if; depends on nothing.
package sss_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int DIV_W             = 48;
    localparam int CFG_W             = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int TPS_W             = 27;
    localparam int ROT_W             = 32;
    localparam int AMT_W             = 32;
    localparam int OP_W              = 3;

    localparam longint US_PER_S  = 1000000;
    localparam longint RPS_SCALE = 100;
    localparam logic [DIV_W-1:0] SPEED_NUM = DIV_W'(US_PER_S * RPS_SCALE);

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ROTATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_FOREVER = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_POS = 3'd3;
    localparam logic [OP_W-1:0] OP_HOME    = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_OFF = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_DIR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_US    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRT_STEPS = 3'd5;

    localparam logic [1:0] MODE_WAVE    = 2'd0;
    localparam logic [1:0] MODE_FULL    = 2'd1;
    localparam logic [1:0] MODE_HALF    = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_SPD_MUL1, S_SPD_MUL2, S_SPD_DIV, S_SPD_END,
        S_VFR_D1, S_VFR_MUL, S_VFR_D2, S_VFR_END,
        S_TICK_DIV, S_TICK_STEP,
        S_ROT_DIV, S_ROT_SAVE,
        S_RFV_MUL, S_RFV_D1, S_RFV_D2, S_RFV_SAVE, S_RFV_D3, S_RFV_FIX,
        S_PUT
    } t_state;

    typedef enum logic [2:0] {
        DS_SPEED, DS_VFR1, DS_VFR2, DS_ROT, DS_RFV1, DS_RFV2, DS_RFV3, DS_TICK
    } t_div_sel;

    typedef struct packed {
        logic     ready;
        logic     clr_dirty;
        logic     tick_count;
        logic     tick_start;
        logic     tick_step;
        logic     set_spin;
        logic     home;
        logic     set_pos;
        logic     set_off;
        logic     rot_save;
        logic     rfv_mul;
        logic     rfv_save;
        logic     rfv_fix;
        logic     spd_clear;
        logic     spd_mul1;
        logic     spd_mul2;
        logic     spd_end;
        logic     vfr_mul;
        logic     vfr_end;
        logic     out_load;
        logic     div_req;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic            dirty;
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            stop;
        logic            cd_zero;
        logic            spd_zero;
        logic            div_done;
        logic            out_free;
    } t_stat;

    function automatic logic [3:0] coil_pattern(logic [1:0] mode, logic [2:0] idx);
        logic [3:0] pat;
        case (mode)
            MODE_HALF: begin
                case (idx)
                    3'd0:    pat = 4'h9;
                    3'd1:    pat = 4'h1;
                    3'd2:    pat = 4'h3;
                    3'd3:    pat = 4'h2;
                    3'd4:    pat = 4'h6;
                    3'd5:    pat = 4'h4;
                    3'd6:    pat = 4'hC;
                    default: pat = 4'h8;
                endcase
            end
            MODE_FULL: begin
                case (idx[1:0])
                    2'd0:    pat = 4'h9;
                    2'd1:    pat = 4'h3;
                    2'd2:    pat = 4'h6;
                    default: pat = 4'hC;
                endcase
            end
            default: begin
                case (idx[1:0])
                    2'd0:    pat = 4'h1;
                    2'd1:    pat = 4'h2;
                    2'd2:    pat = 4'h4;
                    default: pat = 4'h8;
                endcase
            end
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/sss_in_if.sv
// Input channel of the stepper step sequencer: valid, ready, opcode, amount.
// Depends on sss_pkg for the field widths.
interface sss_in_if;
    logic                       valid;
    logic                       ready;
    logic [sss_pkg::OP_W-1:0]   opcode;
    logic [sss_pkg::AMT_W-1:0]  amount;

    modport source (output valid, output opcode, output amount, input ready);
    modport sink   (input valid, input opcode, input amount, output ready);
endinterface

// File: rtl/sss_out_if.sv
// Result channel of the stepper step sequencer: valid, ready and result fields.
// Stands alone; the field widths are fixed.
interface sss_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  coils;
    logic        step_done;
    logic        spinning;
    logic [15:0] target_position;

    modport source (output valid, output coils, output step_done, output spinning,
                    output target_position, input ready);
    modport sink   (input valid, input coils, input step_done, input spinning,
                    input target_position, output ready);
endinterface

// File: rtl/sss_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on sss_pkg for the operand width.
module sss_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sss_pkg::DIV_W-1:0]  i_dividend,
    input  logic [sss_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [sss_pkg::DIV_W-1:0]  o_quo,
    output logic [sss_pkg::DIV_W-1:0]  o_rem
);
    import sss_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo, r_rem, r_dvs;
    logic [DIV_W:0]   trial, diff;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DIV_W]) begin
                r_rem <= diff[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == LAST);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// File: rtl/sss_ctrl.sv
// Controller of the stepper step sequencer: sequences the datapath steps of
// every item and of the speed and target recompute. Depends on sss_pkg.
module sss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sss_pkg::t_stat i_stat,
    output sss_pkg::t_cmd  o_cmd
);
    import sss_pkg::*;

    t_state r_state, n_state;
    logic   r_item, n_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_item  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_item  <= n_item;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        case (r_state)
            S_IDLE: begin
                if (i_stat.dirty) begin
                    n_state = S_SPD_MUL1;
                end else if (i_stat.in_valid) begin
                    n_state = S_DISPATCH;
                    n_item  = 1'b1;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_TICK: begin
                        if (i_stat.stop || !i_stat.cd_zero) n_state = S_PUT;
                        else n_state = S_TICK_DIV;
                    end
                    OP_ROTATE:  n_state = S_ROT_DIV;
                    OP_SET_POS: n_state = S_RFV_MUL;
                    OP_SET_OFF: n_state = S_RFV_MUL;
                    default:    n_state = S_PUT;
                endcase
            end
            S_SPD_MUL1:  n_state = i_stat.spd_zero ? S_VFR_D1 : S_SPD_MUL2;
            S_SPD_MUL2:  n_state = S_SPD_DIV;
            S_SPD_DIV:   if (i_stat.div_done) n_state = S_SPD_END;
            S_SPD_END:   n_state = S_VFR_D1;
            S_VFR_D1:    if (i_stat.div_done) n_state = S_VFR_MUL;
            S_VFR_MUL:   n_state = S_VFR_D2;
            S_VFR_D2:    if (i_stat.div_done) n_state = S_VFR_END;
            S_VFR_END:   n_state = r_item ? S_PUT : S_IDLE;
            S_TICK_DIV:  if (i_stat.div_done) n_state = S_TICK_STEP;
            S_TICK_STEP: n_state = S_PUT;
            S_ROT_DIV:   if (i_stat.div_done) n_state = S_ROT_SAVE;
            S_ROT_SAVE:  n_state = S_RFV_MUL;
            S_RFV_MUL:   n_state = S_RFV_D1;
            S_RFV_D1:    if (i_stat.div_done) n_state = S_RFV_D2;
            S_RFV_D2:    if (i_stat.div_done) n_state = S_RFV_SAVE;
            S_RFV_SAVE:  n_state = S_RFV_D3;
            S_RFV_D3:    if (i_stat.div_done) n_state = S_RFV_FIX;
            S_RFV_FIX:   n_state = S_VFR_D1;
            S_PUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                    n_item  = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        o_cmd.div_sel = DS_SPEED;
        case (r_state)
            S_IDLE: begin
                o_cmd.ready     = !i_stat.dirty;
                o_cmd.clr_dirty = i_stat.dirty;
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_TICK: begin
                        if (!i_stat.stop) begin
                            o_cmd.tick_count = !i_stat.cd_zero;
                            o_cmd.tick_start = i_stat.cd_zero;
                        end
                    end
                    OP_FOREVER: o_cmd.set_spin = 1'b1;
                    OP_SET_POS: o_cmd.set_pos  = 1'b1;
                    OP_HOME:    o_cmd.home     = 1'b1;
                    OP_SET_OFF: o_cmd.set_off  = 1'b1;
                    default:    o_cmd.ready    = 1'b0;
                endcase
            end
            S_SPD_MUL1: begin
                o_cmd.spd_clear = i_stat.spd_zero;
                o_cmd.spd_mul1  = !i_stat.spd_zero;
            end
            S_SPD_MUL2: o_cmd.spd_mul2 = 1'b1;
            S_SPD_DIV: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_SPEED;
            end
            S_SPD_END: o_cmd.spd_end = 1'b1;
            S_VFR_D1: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_VFR1;
            end
            S_VFR_MUL: o_cmd.vfr_mul = 1'b1;
            S_VFR_D2: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_VFR2;
            end
            S_VFR_END: o_cmd.vfr_end = 1'b1;
            S_TICK_DIV: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_TICK;
            end
            S_TICK_STEP: o_cmd.tick_step = 1'b1;
            S_ROT_DIV: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_ROT;
            end
            S_ROT_SAVE: o_cmd.rot_save = 1'b1;
            S_RFV_MUL:  o_cmd.rfv_mul  = 1'b1;
            S_RFV_D1: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_RFV1;
            end
            S_RFV_D2: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_RFV2;
            end
            S_RFV_SAVE: o_cmd.rfv_save = 1'b1;
            S_RFV_D3: begin
                o_cmd.div_req = 1'b1;
                o_cmd.div_sel = DS_RFV3;
            end
            S_RFV_FIX: o_cmd.rfv_fix  = 1'b1;
            S_PUT:     o_cmd.out_load = i_stat.out_free;
            default:   o_cmd.ready    = 1'b0;
        endcase
    end
endmodule

// File: rtl/sss_dp.sv
// Datapath of the stepper step sequencer: configuration, motion state, the
// shared divider, products and the result register. Depends on sss_pkg,
// sss_in_if, sss_out_if and sss_div.
module sss_dp #(
    parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sss_pkg::CFG_W-1:0]     i_cfg_data,
    sss_in_if.sink                        i_cmd,
    sss_out_if.source                     o_res,
    input  sss_pkg::t_cmd                 i_ctl,
    output sss_pkg::t_stat                o_stat
);
    import sss_pkg::*;

    localparam int PW = POSITION_BITS;

    // Configuration.
    logic [1:0]       r_mode;
    logic             r_dir;
    logic [CFG_W-1:0] r_spd, r_tp, r_real, r_virt;
    logic             r_dirty;

    // Motion state.
    logic [2:0]       r_idx;
    logic [TPS_W-1:0] r_cd, r_tps;
    logic [PW-1:0]    r_pos, r_tgt, r_off;
    logic [ROT_W-1:0] r_rot;
    logic             r_spin;
    logic [15:0]      r_tvirt;

    // Working registers.
    logic [OP_W-1:0]  r_op;
    logic [AMT_W-1:0] r_amt;
    logic [AMT_W-1:0] r_rv;
    logic [15:0]      r_tmp;
    logic [DIV_W-1:0] r_prod;
    logic [3:0]       r_coils;
    logic             r_done;

    // Result register.
    logic        r_ov, r_o_done, r_o_spin;
    logic [3:0]  r_o_coils;
    logic [15:0] r_o_tgt;

    logic [CFG_W-1:0] eff_r, eff_v, eff_tp;
    logic             accept;
    logic             cfg_recalc;
    logic             div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_a, div_b, div_quo, div_rem;
    logic [15:0]      p_cur, p_new;
    logic [DIV_W-1:0] p_new_ext, fix_ext;
    logic [PW-1:0]    pos_new;
    logic [16:0]      fix_sum, fix_red;
    logic [31:0]      mul_tp_r;
    logic [32:0]      mul_vfr;
    logic [DIV_W-1:0] mul_rfv, mul_spd;

    assign eff_r  = (r_real == '0) ? CFG_W'(1) : r_real;
    assign eff_v  = (r_virt == '0) ? eff_r : r_virt;
    assign eff_tp = (r_tp == '0) ? CFG_W'(1) : r_tp;

    assign i_cmd.ready = i_ctl.ready;
    assign accept      = i_ctl.ready && i_cmd.valid;

    // Writes that change the speed or the step scaling need a recompute.
    assign cfg_recalc = i_cfg_we && (i_cfg_idx == CFG_SPEED || i_cfg_idx == CFG_TICK_US ||
                                     i_cfg_idx == CFG_REAL_STEPS ||
                                     i_cfg_idx == CFG_VIRT_STEPS);

    always_comb begin
        case (i_ctl.div_sel)
            DS_SPEED: begin div_a = SPEED_NUM;                       div_b = r_prod;           end
            DS_VFR1:  begin div_a = DIV_W'(r_tgt) + DIV_W'(r_off);   div_b = DIV_W'(eff_r);    end
            DS_VFR2:  begin div_a = r_prod;                          div_b = DIV_W'({eff_r, 1'b0}); end
            DS_ROT:   begin div_a = DIV_W'(r_amt);                   div_b = DIV_W'(eff_v);    end
            DS_RFV1:  begin div_a = r_prod;                          div_b = DIV_W'(eff_v);    end
            DS_RFV2:  begin div_a = div_quo;                         div_b = DIV_W'(eff_r);    end
            DS_RFV3:  begin div_a = DIV_W'(r_off);                   div_b = DIV_W'(eff_r);    end
            default:  begin div_a = DIV_W'(r_pos);                   div_b = DIV_W'(eff_r);    end
        endcase
    end

    assign div_start = i_ctl.div_req && !div_busy;

    sss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // One sequence step from the reduced position.
    assign p_cur = div_rem[15:0];
    always_comb begin
        if (r_dir) begin
            p_new = (p_cur == '0) ? eff_r - 16'd1 : p_cur - 16'd1;
        end else begin
            p_new = (({1'b0, p_cur} + 17'd1) == {1'b0, eff_r}) ? 16'd0 : p_cur + 16'd1;
        end
    end
    assign p_new_ext = DIV_W'(p_new);
    assign pos_new   = p_new_ext[PW-1:0];

    // Target fixup: both terms are below the real step count.
    assign fix_sum = {1'b0, r_tmp} + {1'b0, eff_r} - {1'b0, div_rem[15:0]};
    assign fix_red = (fix_sum >= {1'b0, eff_r}) ? fix_sum - {1'b0, eff_r} : fix_sum;
    assign fix_ext = DIV_W'(fix_red);

    assign mul_tp_r = 32'(eff_tp) * 32'(eff_r);
    assign mul_vfr  = 33'({div_rem[15:0], 1'b0}) * 33'(eff_v);
    assign mul_rfv  = DIV_W'(r_rv) * DIV_W'(eff_r);
    assign mul_spd  = DIV_W'(r_prod[31:0]) * DIV_W'(r_spd);

    // Configuration and recompute request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_WAVE;
            r_dir   <= 1'b0;
            r_spd   <= '0;
            r_tp    <= CFG_W'(100);
            r_real  <= CFG_W'(2048);
            r_virt  <= '0;
            r_dirty <= 1'b0;
        end else begin
            if (cfg_recalc) begin
                r_dirty <= 1'b1;
            end else if (i_ctl.clr_dirty) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DRIVE_MODE: if (i_cfg_data[1:0] != MODE_INVALID) r_mode <= i_cfg_data[1:0];
                    CFG_SPIN_DIR:   r_dir  <= i_cfg_data[0];
                    CFG_SPEED:      r_spd  <= i_cfg_data;
                    CFG_TICK_US:    r_tp   <= i_cfg_data;
                    CFG_REAL_STEPS: r_real <= i_cfg_data;
                    CFG_VIRT_STEPS: r_virt <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Motion state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_cd    <= '0;
            r_tps   <= '0;
            r_pos   <= '0;
            r_tgt   <= '0;
            r_off   <= '0;
            r_rot   <= '0;
            r_spin  <= 1'b0;
            r_tvirt <= '0;
        end else begin
            if (i_ctl.tick_count) r_cd <= r_cd - TPS_W'(1);
            if (i_ctl.tick_step) begin
                r_cd <= r_tps;
                if (r_mode == MODE_HALF) begin
                    r_idx <= r_dir ? r_idx - 3'd1 : r_idx + 3'd1;
                end else begin
                    r_idx <= {1'b0, r_dir ? r_idx[1:0] - 2'd1 : r_idx[1:0] + 2'd1};
                end
                if (!r_spin) begin
                    r_pos <= pos_new;
                    if (pos_new == r_tgt && r_rot != '0) r_rot <= r_rot - ROT_W'(1);
                end
            end
            if (i_ctl.set_spin) r_spin <= 1'b1;
            if (i_ctl.home)     r_pos  <= '0;
            if (i_ctl.set_off)  r_off  <= r_amt[PW-1:0];
            if (i_ctl.rot_save) r_rot  <= div_quo[ROT_W-1:0];
            if (i_ctl.rfv_fix) begin
                r_tgt  <= fix_ext[PW-1:0];
                r_spin <= 1'b0;
            end
            if (i_ctl.spd_clear) r_tps   <= '0;
            if (i_ctl.spd_end)   r_tps   <= div_quo[TPS_W-1:0];
            if (i_ctl.vfr_end)   r_tvirt <= div_quo[15:0];
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_cmd.opcode;
            r_amt   <= i_cmd.amount;
            r_coils <= '0;
            r_done  <= 1'b0;
        end
        if (i_ctl.tick_count || i_ctl.tick_start) r_coils <= coil_pattern(r_mode, r_idx);
        if (i_ctl.tick_step) r_done <= 1'b1;
        if (i_ctl.set_pos)   r_rv <= r_amt;
        if (i_ctl.set_off)   r_rv <= AMT_W'(r_tvirt);
        if (i_ctl.rot_save)  r_rv <= AMT_W'(r_tvirt) + div_rem[AMT_W-1:0];
        if (i_ctl.rfv_save)  r_tmp <= div_rem[15:0];
        if (i_ctl.rfv_mul)   r_prod <= mul_rfv;
        if (i_ctl.spd_mul1)  r_prod <= DIV_W'(mul_tp_r);
        if (i_ctl.spd_mul2)  r_prod <= mul_spd;
        if (i_ctl.vfr_mul)   r_prod <= DIV_W'(mul_vfr) + DIV_W'(eff_r);
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_o_coils <= r_coils;
            r_o_done  <= r_done;
            r_o_spin  <= r_spin || (r_pos != r_tgt) || (r_rot != '0);
            r_o_tgt   <= r_tvirt;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.coils           = r_o_coils;
    assign o_res.step_done       = r_o_done;
    assign o_res.spinning        = r_o_spin;
    assign o_res.target_position = r_o_tgt;

    always_comb begin
        o_stat.dirty    = r_dirty;
        o_stat.in_valid = i_cmd.valid;
        o_stat.op       = r_op;
        o_stat.stop     = (!r_spin && (r_pos == r_tgt) && (r_rot == '0)) || (r_tps == '0);
        o_stat.cd_zero  = (r_cd == '0);
        o_stat.spd_zero = (r_spd == '0);
        o_stat.div_done = div_done;
        o_stat.out_free = !r_ov || o_res.ready;
    end
endmodule

// File: rtl/stepper_step_sequencer.sv
// Stepper step sequencer, one item at a time. A tick that does not step, rotate forever,
// home and the spare opcodes need no divider pass; a stepping tick divides once; set
// position and set offset run the target recompute, and rotate runs a divide before it.
// Each pass of the shared divider loads its operands and then develops the quotient. The
// next item is taken while a result waits. A speed, tick period or step count write runs a
// recompute before the next item. Synchronous active-low reset clears config and motion state.
module stepper_step_sequencer #(
    parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sss_pkg::CFG_W-1:0]     i_cfg_data,
    sss_in_if.sink                        i_cmd,
    sss_out_if.source                     o_res
);
    import sss_pkg::*;

    // The controller issues one command word per cycle; the datapath reports
    // back the few conditions that steer the sequence.
    t_cmd  ctl;
    t_stat stat;

    sss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (ctl)
    );

    // The datapath holds configuration, position state, the divider and the
    // result register that decouples the result side from the input side.
    sss_dp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .o_res      (o_res),
        .i_ctl      (ctl),
        .o_stat     (stat)
    );
endmodule
